// ===== design/stream_expression_calculator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef STREAM_EXPRESSION_CALCULATOR_DEFINES_SVH
`define STREAM_EXPRESSION_CALCULATOR_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define SEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while in reset.
`define SEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define SEC_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sec_pkg.sv =====
package sec_pkg;

  localparam int RESULT_BITS = 32;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_TIMES   = 8'h2A;
  localparam logic [7:0] CH_DIVIDE  = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BELL    = 8'h07;

  typedef enum logic [1:0] {
    OP_PLUS,
    OP_MINUS,
    OP_TIMES,
    OP_DIVIDE
  } op_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result_value;
    logic                          div_fault;
    logic                          bad_char_seen;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic apply;
    logic finish;
    logic set_op;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_oper;
    logic in_last;
    logic last_held;
    logic apply_long;
    logic mdu_done;
  } dp_sts_t;

  function automatic op_t char_to_op(input logic [7:0] c);
    op_t op;
    case (c)
      CH_PLUS:  op = OP_PLUS;
      CH_MINUS: op = OP_MINUS;
      CH_TIMES: op = OP_TIMES;
      default:  op = OP_DIVIDE;
    endcase
    return op;
  endfunction

endpackage

// ===== design/sec_muldiv.sv =====
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module sec_muldiv #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 is_div,
  input  logic [WORD_BITS-1:0] opa,
  input  logic [WORD_BITS-1:0] opb,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(WORD_BITS - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 div_r, div_nxt;
  logic                 neg_r, neg_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;   // product or partial remainder
  logic [WORD_BITS-1:0] shd_r, shd_nxt;   // multiplier or dividend/quotient
  logic [WORD_BITS-1:0] dvs_r, dvs_nxt;   // multiplicand or divisor

  logic [WORD_BITS-1:0] mag_a, mag_b;
  logic [WORD_BITS:0]   rem_sh, diff;

  assign mag_a  = opa[WORD_BITS-1] ? (~opa + WORD_BITS'(1)) : opa;
  assign mag_b  = opb[WORD_BITS-1] ? (~opb + WORD_BITS'(1)) : opb;
  assign rem_sh = {rem_r, shd_r[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    shd_nxt  = shd_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = is_div;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
      if (is_div) begin
        shd_nxt = mag_a;
        dvs_nxt = mag_b;
      end else begin
        shd_nxt = opb;
        dvs_nxt = opa;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (div_r) begin
        if (!diff[WORD_BITS]) begin
          rem_nxt = diff[WORD_BITS-1:0];
          shd_nxt = {shd_r[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[WORD_BITS-1:0];
          shd_nxt = {shd_r[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        if (shd_r[0]) begin
          rem_nxt = rem_r + dvs_r;
        end
        dvs_nxt = {dvs_r[WORD_BITS-2:0], 1'b0};
        shd_nxt = {1'b0, shd_r[WORD_BITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    shd_r <= shd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;

  always_comb begin
    if (!div_r) begin
      result = rem_r;
    end else if (neg_r) begin
      result = ~shd_r + WORD_BITS'(1);
    end else begin
      result = shd_r;
    end
  end

endmodule

// ===== design/sec_datapath.sv =====
module sec_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sec_pkg::in_item_t   in_data,
  input  sec_pkg::dp_cmd_t    cmd,
  output sec_pkg::dp_sts_t    sts,
  output sec_pkg::out_item_t  out_data
);

  localparam int RB = sec_pkg::RESULT_BITS;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] opnd_r, opnd_nxt;
  sec_pkg::op_t         pend_r, pend_nxt;
  sec_pkg::op_t         new_op_r, new_op_nxt;
  logic                 last_r, last_nxt;
  logic                 fault_r, fault_nxt;
  logic                 skip_r, skip_nxt;
  sec_pkg::out_item_t   out_r, out_nxt;

  logic                 in_oper, in_skip, div_ok, apply_long;
  logic [WORD_BITS-1:0] digit_val;
  logic [WORD_BITS-1:0] mdu_result;
  logic                 mdu_done;
  logic [WORD_BITS+RB-1:0] acc_ext;

  assign in_oper = (in_data.char_code == sec_pkg::CH_PLUS)  ||
                   (in_data.char_code == sec_pkg::CH_MINUS) ||
                   (in_data.char_code == sec_pkg::CH_TIMES) ||
                   (in_data.char_code == sec_pkg::CH_DIVIDE);
  assign in_skip = (in_data.char_code == sec_pkg::CH_NEWLINE) ||
                   (in_data.char_code == sec_pkg::CH_TAB)     ||
                   (in_data.char_code == sec_pkg::CH_BELL)    ||
                   (in_data.char_code == sec_pkg::CH_SPACE);

  // operand*10 + (char - '0'), wrapped
  assign digit_val = {opnd_r[WORD_BITS-4:0], 3'b000} + {opnd_r[WORD_BITS-2:0], 1'b0}
                   + WORD_BITS'(in_data.char_code) - WORD_BITS'(sec_pkg::CH_ZERO);

  assign div_ok     = (acc_r != '0) && (opnd_r != '0);
  assign apply_long = (pend_r == sec_pkg::OP_TIMES) ||
                      ((pend_r == sec_pkg::OP_DIVIDE) && div_ok);
  assign acc_ext    = {{RB{1'b0}}, acc_r};

  sec_muldiv #(
    .WORD_BITS (WORD_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.apply && apply_long),
    .is_div (pend_r == sec_pkg::OP_DIVIDE),
    .opa    (acc_r),
    .opb    (opnd_r),
    .done   (mdu_done),
    .result (mdu_result)
  );

  always_comb begin
    acc_nxt    = acc_r;
    opnd_nxt   = opnd_r;
    pend_nxt   = pend_r;
    new_op_nxt = new_op_r;
    last_nxt   = last_r;
    fault_nxt  = fault_r;
    skip_nxt   = skip_r;
    out_nxt    = out_r;

    if (cmd.take) begin
      last_nxt = in_data.last_char;
      if (in_oper) begin
        new_op_nxt = sec_pkg::char_to_op(in_data.char_code);
      end else if (in_skip) begin
        skip_nxt = 1'b1;
      end else begin
        opnd_nxt = digit_val;
      end
    end

    if (cmd.apply) begin
      case (pend_r)
        sec_pkg::OP_PLUS: begin
          acc_nxt  = acc_r + opnd_r;
          opnd_nxt = '0;
        end
        sec_pkg::OP_MINUS: begin
          acc_nxt  = acc_r - opnd_r;
          opnd_nxt = '0;
        end
        sec_pkg::OP_DIVIDE: begin
          if (!div_ok) begin
            fault_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.finish) begin
      acc_nxt  = mdu_result;
      opnd_nxt = '0;
    end

    if (cmd.set_op) begin
      pend_nxt = new_op_r;
    end

    if (cmd.emit) begin
      out_nxt.result_value  = $signed(acc_ext[RB-1:0]);
      out_nxt.div_fault     = fault_r;
      out_nxt.bad_char_seen = skip_r;
      acc_nxt   = '0;
      opnd_nxt  = '0;
      pend_nxt  = sec_pkg::OP_PLUS;
      fault_nxt = 1'b0;
      skip_nxt  = 1'b0;
      last_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      opnd_r   <= '0;
      pend_r   <= sec_pkg::OP_PLUS;
      new_op_r <= sec_pkg::OP_PLUS;
      last_r   <= 1'b0;
      fault_r  <= 1'b0;
      skip_r   <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      opnd_r   <= opnd_nxt;
      pend_r   <= pend_nxt;
      new_op_r <= new_op_nxt;
      last_r   <= last_nxt;
      fault_r  <= fault_nxt;
      skip_r   <= skip_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_data       = out_r;
  assign sts.in_oper    = in_oper;
  assign sts.in_last    = in_data.last_char;
  assign sts.last_held  = last_r;
  assign sts.apply_long = apply_long;
  assign sts.mdu_done   = mdu_done;

endmodule

// ===== design/sec_control.sv =====
module sec_control (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sec_pkg::dp_sts_t  sts,
  output sec_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_WAIT,
    S_POST,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;       // applying the closing operation
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.in_oper) begin
            final_nxt = 1'b0;
            state_nxt = S_APPLY;
          end else if (sts.in_last) begin
            final_nxt = 1'b1;
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.apply_long ? S_WAIT : S_POST;
      end
      S_WAIT: begin
        if (sts.mdu_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_POST;
        end
      end
      S_POST: begin
        if (!final_r) begin
          cmd.set_op = 1'b1;
          if (sts.last_held) begin
            final_nxt = 1'b1;
            state_nxt = S_APPLY;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/stream_expression_calculator.sv =====
// Left-to-right expression calculator: feed one ASCII character per transaction, with
// last_char set on the final one, and one result transaction comes back per expression
// holding the wrapped accumulator, a division-fault flag and a skipped-character flag.
// There is no operator precedence; '+', '-', '*' and '/' apply the pending operator,
// newline, tab, bell and space are dropped (setting the skip flag), and every other
// byte counts as a digit. A digit or skipped character other than the last leaves the
// block ready for the next character; an operator first runs the apply and post steps,
// and a multiply or real division also waits on the shared multiply/divide unit, which
// retires one bit per cycle. The last character adds one more apply pass and a load of
// the result register, and that load waits while the previous result is still held.
// The result register sits apart from the input side, so a waiting result does not
// stall new characters until the next result is ready to be loaded.
module stream_expression_calculator #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sec_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sec_pkg::out_item_t  out_data
);

  sec_pkg::dp_cmd_t cmd;
  sec_pkg::dp_sts_t sts;

  // Sequence take / apply / wait / update-operator / emit steps.
  sec_control u_control (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold accumulator, operand, pending operator, flags and the result register.
  sec_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== design/sec_checker.sv =====
`include "stream_expression_calculator_defines.svh"

module sec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sec_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sec_pkg::out_item_t out_data
);

  logic in_acc, in_oper;

  assign in_acc  = in_valid && in_ready;
  assign in_oper = (in_data.char_code == sec_pkg::CH_PLUS)  ||
                   (in_data.char_code == sec_pkg::CH_MINUS) ||
                   (in_data.char_code == sec_pkg::CH_TIMES) ||
                   (in_data.char_code == sec_pkg::CH_DIVIDE);

  `SEC_ASSERT_ALWAYS_NEXT(a_reset_clears_out, !rst_n, !out_valid, "result valid after reset")
  `SEC_ASSERT_NEXT(a_no_result_after_accept, in_acc, !$rose(out_valid), "result too early")
  `SEC_ASSERT_NEXT(a_oper_busy, in_acc && in_oper, !in_ready, "ready during operator apply")
  `SEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `SEC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")

endmodule

bind stream_expression_calculator sec_checker u_sec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
